// ----- hw/rtl/apd_pkg.sv -----
// Package for the autobaud pulse detector: field widths, register indexes,
// default parameter values and the table of standard baud rates.
// No dependencies.
package apd_pkg;

	localparam int APD_DEF_TIME_WIDTH    = 32;
	localparam int APD_DEF_RATE_ENTRIES  = 9;
	localparam int APD_STD_RATE_COUNT    = 9;
	localparam int APD_RATE_W            = 32;
	localparam int APD_MIN_PULSE_W       = 16;
	localparam int APD_CFG_INDEX_W       = 2;
	localparam int APD_S_TDATA_W         = 32;
	localparam int APD_M_TDATA_W         = 72;

	localparam logic [APD_MIN_PULSE_W-1:0] APD_RST_MIN_PULSE = 16'd5;
	localparam logic [APD_RATE_W-1:0]      APD_RST_TICKS     = 32'd1000000;
	localparam logic [APD_RATE_W-1:0]      APD_RST_FALLBACK  = 32'd115200;

	typedef enum logic [APD_CFG_INDEX_W-1:0] {
		REG_MIN_PULSE = 2'd0,
		REG_TICKS     = 2'd1,
		REG_FALLBACK  = 2'd2
	} apd_cfg_reg_t;

	localparam logic CMD_RESTART = 1'b0;
	localparam logic CMD_EDGE    = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} apd_unit_stat_t;

	function automatic logic [APD_RATE_W-1:0] apd_std_rate(input logic [3:0] idx);
		logic [APD_RATE_W-1:0] r;
		unique case (idx)
			4'd0:    r = 32'd9600;
			4'd1:    r = 32'd19200;
			4'd2:    r = 32'd38400;
			4'd3:    r = 32'd57600;
			4'd4:    r = 32'd115200;
			4'd5:    r = 32'd230400;
			4'd6:    r = 32'd250000;
			4'd7:    r = 32'd500000;
			4'd8:    r = 32'd1000000;
			default: r = 32'd9600;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/apd_div.sv -----
// Restoring divider for the autobaud pulse detector: one quotient bit per cycle
// through a single shared subtract-and-compare unit.
// Depends on apd_pkg.
module apd_div import apd_pkg::*; #(
	parameter int TIME_WIDTH = APD_DEF_TIME_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [APD_RATE_W-1:0]   dividend,
	input  logic [TIME_WIDTH-1:0]   divisor,
	output logic [APD_RATE_W-1:0]   quotient,
	output apd_unit_stat_t          stat
);

	localparam int CW = $clog2(APD_RATE_W);

	logic [TIME_WIDTH:0]   rem_q;
	logic [APD_RATE_W-1:0] quo_q;
	logic [TIME_WIDTH-1:0] dsr_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [TIME_WIDTH:0]   shifted;
	logic [TIME_WIDTH:0]   diff;
	logic                  fits;

	always_comb begin
		shifted = {rem_q[TIME_WIDTH-1:0], quo_q[APD_RATE_W-1]};
		diff    = shifted - {1'b0, dsr_q};
		fits    = shifted >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(APD_RATE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff : shifted;
			quo_q <= {quo_q[APD_RATE_W-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- hw/rtl/apd_snap.sv -----
// Nearest standard rate search for the autobaud pulse detector: one table
// entry per cycle through a shared difference and compare unit.
// Depends on apd_pkg.
module apd_snap import apd_pkg::*; #(
	parameter int RAW_W   = APD_RATE_W,
	parameter int ENTRIES = APD_STD_RATE_COUNT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [RAW_W-1:0]      raw,
	output logic [APD_RATE_W-1:0] best,
	output apd_unit_stat_t        stat
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [RAW_W-1:0]      raw_q;
	logic [RAW_W-1:0]      best_diff_q;
	logic [APD_RATE_W-1:0] best_q;
	logic [IW-1:0]         idx_q;
	logic                  first_q;
	logic                  busy_q;
	logic                  done_q;
	logic [APD_RATE_W-1:0] rate;
	logic [RAW_W-1:0]      rate_ext;
	logic [RAW_W-1:0]      diff;

	always_comb begin
		rate     = apd_std_rate(4'(idx_q));
		rate_ext = RAW_W'(rate);
		diff     = (raw_q > rate_ext) ? (raw_q - rate_ext) : (rate_ext - raw_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				idx_q   <= '0;
			end else if (busy_q) begin
				first_q <= 1'b0;
				if (idx_q == IW'(ENTRIES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			raw_q <= raw;
		end else if (busy_q && (first_q || diff < best_diff_q)) begin
			best_diff_q <= diff;
			best_q      <= rate;
		end
	end

	assign best      = best_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- hw/rtl/autobaud_pulse_detector.sv -----
// Top level of the autobaud pulse detector: stream ports, configuration
// registers, pulse state and the sequencer over the divider and rate search.
// Depends on apd_pkg, apd_div and apd_snap.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  s_*      | s_tvalid/s_tready  | tuser: command; tdata: edge_time
//  m_*      | m_tvalid/m_tready  | tdata: detected, shortest_pulse_out, baud
//  cfg_*    | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An edge that needs a quotient is evaluated, then runs through the bit-serial divider,
// the rate table search and the hand-over to the output register. A zero shortest pulse
// skips the divider and goes straight to the search; a restart or an edge without
// detection skips both the divider and the search.
// Reset clears the pulse state and loads the register defaults. The input is ready
// again once the result is registered, and a result still waiting at m_* holds the
// next one in its final state.
module autobaud_pulse_detector import apd_pkg::*; #(
	parameter int TIME_WIDTH         = APD_DEF_TIME_WIDTH,
	parameter int RATE_TABLE_ENTRIES = APD_DEF_RATE_ENTRIES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [APD_S_TDATA_W-1:0]   s_tdata,   // [31:0] edge_time
	input  logic [0:0]                 s_tuser,   // [0] command
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [APD_M_TDATA_W-1:0]   m_tdata,   // [0] detected, [32:1] shortest, [64:33] baud
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [APD_CFG_INDEX_W-1:0] cfg_index,
	input  logic [APD_RATE_W-1:0]      cfg_data
);

	localparam int RAW_W  = (TIME_WIDTH > APD_RATE_W) ? TIME_WIDTH : APD_RATE_W;
	localparam int SNAP_N = (RATE_TABLE_ENTRIES < APD_STD_RATE_COUNT) ?
		RATE_TABLE_ENTRIES : APD_STD_RATE_COUNT;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_SNAP,
		S_DONE
	} state_t;

	state_t                      state_q;
	logic [APD_MIN_PULSE_W-1:0]  min_pulse_q;
	logic [APD_RATE_W-1:0]       ticks_q;
	logic [APD_RATE_W-1:0]       fallback_q;
	logic [TIME_WIDTH-1:0]       shortest_q;
	logic [TIME_WIDTH-1:0]       last_edge_q;
	logic                        detected_q;
	logic [APD_RATE_W-1:0]       baud_q;
	logic                        m_tvalid_q;
	logic [APD_M_TDATA_W-1:0]    m_tdata_q;

	logic                        s_accept;
	logic [TIME_WIDTH-1:0]       now;
	logic [TIME_WIDTH-1:0]       gap;
	logic                        take;
	logic                        div_start;
	logic                        snap_start;
	logic [RAW_W-1:0]            snap_raw;
	logic [APD_RATE_W-1:0]       div_quo;
	logic [APD_RATE_W-1:0]       snap_best;
	apd_unit_stat_t              div_stat;
	apd_unit_stat_t              snap_stat;
	logic                        no_estimate;
	logic                        zero_pulse;

	assign s_tready  = (state_q == S_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	always_comb begin
		now  = TIME_WIDTH'(s_tdata);
		gap  = now - last_edge_q;
		take = (gap >= TIME_WIDTH'(min_pulse_q)) && (gap < shortest_q);
	end

	always_comb begin
		no_estimate = !detected_q || (shortest_q == {TIME_WIDTH{1'b1}});
		zero_pulse  = (shortest_q == '0);
		div_start   = (state_q == S_EVAL) && !no_estimate && !zero_pulse;
		snap_start  = ((state_q == S_EVAL) && !no_estimate && zero_pulse) ||
			((state_q == S_DIV) && div_stat.done);
		snap_raw    = (state_q == S_EVAL) ? RAW_W'({TIME_WIDTH{1'b1}}) : RAW_W'(div_quo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= APD_RST_MIN_PULSE;
			ticks_q     <= APD_RST_TICKS;
			fallback_q  <= APD_RST_FALLBACK;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_PULSE: min_pulse_q <= cfg_data[APD_MIN_PULSE_W-1:0];
				REG_TICKS:     ticks_q     <= cfg_data;
				REG_FALLBACK:  fallback_q  <= cfg_data;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			shortest_q  <= {TIME_WIDTH{1'b1}};
			last_edge_q <= '0;
			detected_q  <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						if (s_tuser[0] == CMD_RESTART) begin
							shortest_q <= {TIME_WIDTH{1'b1}};
							detected_q <= 1'b0;
						end else begin
							last_edge_q <= now;
							if (take) begin
								shortest_q <= gap;
								detected_q <= 1'b1;
							end
						end
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (no_estimate) begin
						state_q <= S_DONE;
					end else if (zero_pulse) begin
						state_q <= S_SNAP;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_SNAP;
					end
				end
				S_SNAP: begin
					if (snap_stat.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EVAL && no_estimate) begin
			baud_q <= fallback_q;
		end else if (state_q == S_SNAP && snap_stat.done) begin
			baud_q <= snap_best;
		end
		if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {{(APD_M_TDATA_W - 2*APD_RATE_W - 1){1'b0}}, baud_q,
				APD_RATE_W'(shortest_q), detected_q};
		end
	end

	apd_div #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ticks_q),
		.divisor  (shortest_q),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	apd_snap #(
		.RAW_W   (RAW_W),
		.ENTRIES (SNAP_N)
	) u_snap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (snap_start),
		.raw    (snap_raw),
		.best   (snap_best),
		.stat   (snap_stat)
	);

`ifndef ASSERT_OFF
	// The detected flag and an all-ones shortest pulse always exclude each other.
	a_detect_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		detected_q == (shortest_q != {TIME_WIDTH{1'b1}}))
		else $error("detected flag disagrees with the shortest pulse");

	// An accepted transaction blocks the input side on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> !s_tready)
		else $error("input still ready after a transaction was accepted");

	// The divider runs only while the sequencer waits for it.
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == S_DIV)
		else $error("divider busy outside the divide state");

	// The rate search runs only while the sequencer waits for it.
	a_snap_owned: assert property (@(posedge clk) disable iff (!arst_n)
		snap_stat.busy |-> state_q == S_SNAP)
		else $error("rate search busy outside the search state");
`endif

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for autobaud_pulse_detector: directed and random line
// events on the stream ports, with a built-in predictor of pulse state and baud.
// Depends on apd_pkg and the autobaud_pulse_detector RTL.
`timescale 1ns / 1ps

module testbench;
	import apd_pkg::*;

	localparam logic [APD_CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam int  SEARCH_COUNT = (APD_DEF_RATE_ENTRIES < APD_STD_RATE_COUNT) ?
		APD_DEF_RATE_ENTRIES : APD_STD_RATE_COUNT;
	localparam logic [8:0][31:0] STD_RATES = {
		32'd1000000, 32'd500000, 32'd250000, 32'd230400, 32'd115200,
		32'd57600, 32'd38400, 32'd19200, 32'd9600
	};
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic        detected;
		logic [31:0] shortest;
		logic [31:0] baud;
	} baud_report_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [APD_S_TDATA_W-1:0]   s_tdata = '0;
	logic [0:0]                 s_tuser = '0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [APD_M_TDATA_W-1:0]   m_tdata;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [APD_CFG_INDEX_W-1:0] cfg_index = '0;
	logic [APD_RATE_W-1:0]      cfg_data = '0;

	logic [15:0] cfg_min_pulse = APD_RST_MIN_PULSE;
	logic [31:0] cfg_ticks = APD_RST_TICKS;
	logic [31:0] cfg_fallback = APD_RST_FALLBACK;
	logic [31:0] pred_shortest = '1;
	logic [31:0] pred_last_edge = '0;
	logic        pred_detected = 1'b0;

	baud_report_t baud_reports_due[$];
	baud_report_t got_report;
	baud_report_t want_report;
	logic [31:0]  line_time = '0;
	int unsigned  tx_idle_pct = 0;
	int unsigned  rx_idle_pct = 0;
	int unsigned  error_count = 0;
	int unsigned  cycle_count = 0;

	autobaud_pulse_detector u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (error_count < 40)
			$display("Mismatch in %s: got 0x%08h, expected 0x%08h", what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			got_report.detected = m_tdata[0];
			got_report.shortest = m_tdata[32:1];
			got_report.baud     = m_tdata[64:33];
			if (baud_reports_due.size() == 0) begin
				report_mismatch("transaction with nothing pending", m_tdata[31:0], '0);
			end else begin
				want_report = baud_reports_due.pop_front();
				if (got_report.detected !== want_report.detected)
					report_mismatch("detected", 32'(got_report.detected),
						32'(want_report.detected));
				if (got_report.shortest !== want_report.shortest)
					report_mismatch("shortest_pulse_out", got_report.shortest,
						want_report.shortest);
				if (got_report.baud !== want_report.baud)
					report_mismatch("baud_estimate", got_report.baud, want_report.baud);
			end
		end
	end

	function automatic logic [31:0] nearest_std_rate(input logic [63:0] quotient);
		logic [31:0] best;
		logic [63:0] best_gap;
		logic [63:0] rate_gap;
		best = STD_RATES[0];
		best_gap = (quotient > best) ? quotient - best : best - quotient;
		for (int i = 1; i < SEARCH_COUNT; i++) begin
			rate_gap = (quotient > STD_RATES[i]) ? quotient - STD_RATES[i] :
				STD_RATES[i] - quotient;
			// Strictly closer only, so a tie stays with the lower rate.
			if (rate_gap < best_gap) begin
				best_gap = rate_gap;
				best = STD_RATES[i];
			end
		end
		return best;
	endfunction

	task automatic compute_baud_report(input logic cmd, input logic [31:0] stamp);
		baud_report_t report;
		logic [31:0]  gap;
		logic [63:0]  quotient;
		if (cmd == CMD_RESTART) begin
			pred_shortest = '1;
			pred_detected = 1'b0;
		end else begin
			gap = stamp - pred_last_edge;
			pred_last_edge = stamp;
			if (gap >= cfg_min_pulse && gap < pred_shortest) begin
				pred_shortest = gap;
				pred_detected = 1'b1;
			end
		end
		report.detected = pred_detected;
		report.shortest = pred_shortest;
		if (!pred_detected || pred_shortest == '1) begin
			report.baud = cfg_fallback;
		end else begin
			if (pred_shortest == '0)
				quotient = 64'hFFFF_FFFF;
			else
				quotient = {32'd0, cfg_ticks} / {32'd0, pred_shortest};
			report.baud = nearest_std_rate(quotient);
		end
		baud_reports_due.push_back(report);
	endtask

	task automatic send_line_event(input logic cmd, input logic [31:0] stamp);
		int unsigned pause;
		if ($urandom_range(99) < tx_idle_pct) begin
			pause = $urandom_range(1, 60);
			s_tvalid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= stamp;
		do @(posedge clk); while (!s_tready);
		compute_baud_report(cmd, stamp);
	endtask

	task automatic send_edge(input logic [31:0] stamp);
		line_time = stamp;
		send_line_event(CMD_EDGE, stamp);
	endtask

	task automatic wait_all_reported();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (baud_reports_due.size() != 0);
	endtask

	task automatic write_register(input logic [APD_CFG_INDEX_W-1:0] idx,
			input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MIN_PULSE: cfg_min_pulse = value[15:0];
			REG_TICKS:     cfg_ticks = value;
			REG_FALLBACK:  cfg_fallback = value;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [31:0] min_word, input logic [31:0] ticks,
			input logic [31:0] fallback);
		write_register(REG_MIN_PULSE, min_word);
		write_register(REG_TICKS, ticks);
		write_register(REG_UNUSED, $urandom);
		write_register(REG_FALLBACK, fallback);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_bit_period();
		logic [31:0] period;
		period = cfg_ticks / STD_RATES[$urandom_range(0, SEARCH_COUNT - 1)];
		return (period == 0) ? 32'd1 : period;
	endfunction

	// Runs on the reset values of the registers.
	task automatic test_reset_defaults();
		send_line_event(CMD_RESTART, 32'hFFFF_FFFF);
		send_edge(32'd0);
		send_edge(32'd4);
		send_edge(32'd9);
		send_edge(32'd8689);
		send_edge(32'd8693);
		send_line_event(CMD_RESTART, 32'h1234_5678);
		send_edge(32'd8797);
		send_edge(32'hFFFF_FFFF);
		send_edge(32'h0000_0007);
		send_edge(32'h0000_000F);
		send_edge(32'h0000_0015);
	endtask

	task automatic test_register_extremes();
		wait_all_reported();
		// Zero noise guard, so equal timestamps give a zero gap.
		apply_settings(32'hFFFF_0000, 32'hFFFF_FFFF, 32'd1);
		send_line_event(CMD_RESTART, $urandom);
		send_edge(32'd100);
		send_edge(32'd100);
		send_edge(32'd101);
		send_line_event(CMD_RESTART, $urandom);
		send_edge(32'd102);
		wait_all_reported();
		// Quotient halfway between the two lowest rates.
		apply_settings(32'd1, 32'd14400, 32'hFFFF_FFFF);
		send_line_event(CMD_RESTART, $urandom);
		send_edge(32'd103);
		wait_all_reported();
		apply_settings(32'd1, 32'd375000, 32'd57600);
		send_line_event(CMD_RESTART, $urandom);
		send_edge(32'd104);
		wait_all_reported();
		apply_settings(32'h0000_FFFF, 32'd1, 32'h8000_0000);
		send_line_event(CMD_RESTART, $urandom);
		send_edge(32'd104 + 32'd65534);
		send_edge(32'd104 + 32'd65534 + 32'd65535);
	endtask

	task automatic run_random_chunks(input int chunks, input int per_chunk);
		logic [31:0] min_word;
		logic [31:0] ticks;
		logic [31:0] fallback;
		logic [31:0] period;
		int unsigned pick;
		for (int c = 0; c < chunks; c++) begin
			wait_all_reported();
			pick = $urandom_range(9);
			min_word = {16'($urandom_range(0, 65535)), 16'd0};
			case (pick)
				0:       min_word[15:0] = 16'd0;
				1:       min_word[15:0] = 16'hFFFF;
				2:       min_word[15:0] = 16'($urandom_range(0, 65535));
				default: min_word[15:0] = 16'($urandom_range(1, 12));
			endcase
			case ($urandom_range(7))
				1:       ticks = 32'd16000000;
				2:       ticks = 32'd48000000;
				3:       ticks = 32'hFFFF_FFFF;
				4:       ticks = $urandom;
				default: ticks = 32'd1000000;
			endcase
			fallback = $urandom;
			if (fallback == 0)
				fallback = 32'd1;
			apply_settings(min_word, ticks, fallback);
			period = pick_bit_period();
			for (int n = 0; n < per_chunk; n++) begin
				pick = $urandom_range(99);
				if (pick < 4) begin
					send_line_event(CMD_RESTART, $urandom);
					period = pick_bit_period();
				end else if (pick < 12) begin
					send_edge($urandom);
				end else if (pick < 22) begin
					send_edge(line_time + $urandom_range(0, cfg_min_pulse + 2));
				end else begin
					send_edge(line_time + period * $urandom_range(1, 9) +
						$urandom_range(0, 4) - 2);
				end
			end
		end
	endtask

	task automatic test_random_traffic();
		tx_idle_pct = 7;
		rx_idle_pct = 61;
		run_random_chunks(3, 114);
		tx_idle_pct = 61;
		rx_idle_pct = 7;
		run_random_chunks(3, 114);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random_chunks(3, 114);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_random_traffic();
		wait_all_reported();
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/apd_pkg.sv
hw/rtl/apd_div.sv
hw/rtl/apd_snap.sv
hw/rtl/autobaud_pulse_detector.sv
sim/testbench.sv
